// ----- rtl/pfdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdc_pkg: shared types and constants of the pixel frame deframer/checker
// Field widths, row header/footer codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package pfdc_pkg;

	localparam int WORD_W   = 32;
	localparam int ROW_W    = 6;
	localparam int CHAN_W   = 4;
	localparam int WIDX_W   = 4;
	localparam int ADC_W    = 16;
	localparam int EVT_W    = 2;
	localparam int C4_W     = 4;
	localparam int C16_W    = 16;
	localparam int CTR_W    = C4_W + C16_W;

	// configuration register reset values
	localparam logic [WORD_W-1:0] HEADER_WORD_RST = 32'hAAAA_AAAA;
	localparam logic [WORD_W-1:0] FOOTER_WORD_RST = 32'hF0F0_F0F0;

	// row header and footer codes
	localparam logic [3:0]       ROW_HDR_ID   = 4'hF;
	localparam logic [EVT_W-1:0] ROW_EVT_TYPE = 2'd2;
	localparam logic [3:0]       ROW_FTR_ID   = 4'hE;
	localparam logic [ROW_W-1:0] EVENT_ROW    = 6'd7;

	// result kinds
	localparam logic KIND_PIXEL   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_HEADER_WORD = 1'b0,
		REG_FOOTER_WORD = 1'b1
	} reg_idx_t;

	// configuration seen by the checker
	typedef struct packed {
		logic [WORD_W-1:0] header_word;
		logic [WORD_W-1:0] footer_word;
	} pfdc_cfg_t;

	// registered input item handed to the checker
	typedef struct packed {
		logic              vld;
		logic [WORD_W-1:0] word;
	} pfdc_item_t;

endpackage

// ----- rtl/pfdc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module pfdc_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 48,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/pfdc_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdc_in_stage: input register
// Captures one readout word per transfer; holds it while the checker stalls.
// ----------------------------------------------------------------------------
module pfdc_in_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [pfdc_pkg::WORD_W-1:0] word,
	input  logic                       advance,
	output pfdc_pkg::pfdc_item_t       item
);
	import pfdc_pkg::*;

	logic              vld_s1;
	logic [WORD_W-1:0] word_s1;

	// stage is blocked only when it holds a word the checker cannot take
	assign in_stall = vld_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= word;
		end
	end

	assign item.vld  = vld_s1;
	assign item.word = word_s1;

endmodule

// ----- rtl/pfdc_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdc_engine: frame parser, row checker and result register
// Walks search/rows/footer phases, checks row headers against the counters
// stored per row in the previous frame, and registers one result per data word and a summary per frame footer.
// ----------------------------------------------------------------------------
module pfdc_engine #(
	parameter int ROWS     = 48,
	parameter int CHANNELS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pfdc_pkg::pfdc_cfg_t         cfg,
	input  pfdc_pkg::pfdc_item_t        item,
	output logic                        advance,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        kind,
	output logic [pfdc_pkg::ROW_W-1:0]  row,
	output logic [pfdc_pkg::CHAN_W-1:0] channel,
	output logic [pfdc_pkg::ADC_W-1:0]  adc_even,
	output logic [pfdc_pkg::ADC_W-1:0]  adc_odd,
	output logic                        header_error,
	output logic                        data_error,
	output logic                        footer_error,
	output logic                        frame_error,
	output logic [pfdc_pkg::EVT_W-1:0]  evt_type,
	output logic [pfdc_pkg::C16_W-1:0]  evt_count
);
	import pfdc_pkg::*;

	localparam int DATA_WORDS = CHANNELS / 2;
	localparam int AW         = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
	localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(DATA_WORDS + 1);
	localparam logic [WIDX_W-1:0] WIDX_DATA = WIDX_W'(DATA_WORDS);

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_ROWS,
		PH_FOOTER
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [ROW_W-1:0]    row_q, row_d;
	logic [WIDX_W-1:0]   widx_q, widx_d;
	logic                skipped_q, skipped_d;
	logic                herr_q, herr_d;
	logic                derr_q, derr_d;
	logic [EVT_W-1:0]    evt_type_q, evt_type_d;
	logic [C16_W-1:0]    evt_cnt_q, evt_cnt_d;
	logic [ROWS-1:0]     ctr_vld_q;

	logic [CTR_W-1:0]    ram_rdata;
	logic [CTR_W-1:0]    prev_ctr;
	logic                ctr_we;
	logic                produce;
	logic                res_kind;
	logic [ROW_W-1:0]    res_row;
	logic [CHAN_W-1:0]   res_chan;
	logic                res_ferr;
	logic [WIDX_W-1:0]   widx_m1;

	// per-row counters of the previous frame; read address runs one word ahead
	pfdc_ram #(
		.WIDTH (CTR_W),
		.DEPTH (ROWS),
		.AW    (AW)
	) u_ctr_ram (
		.clk   (clk),
		.we    (ctr_we),
		.waddr (row_q[AW-1:0]),
		.wdata (item.word[CTR_W-1:0]),
		.raddr (row_d[AW-1:0]),
		.rdata (ram_rdata)
	);

	// rows never written since reset read as zero
	assign prev_ctr = ctr_vld_q[row_q[AW-1:0]] ? ram_rdata : '0;

	assign advance = item.vld && (!out_valid || !out_stall);
	assign widx_m1 = widx_q - WIDX_W'(1);

	// next-state and result logic for the word in the input register
	always_comb begin
		phase_d    = phase_q;
		row_d      = row_q;
		widx_d     = widx_q;
		skipped_d  = skipped_q;
		herr_d     = herr_q;
		derr_d     = derr_q;
		evt_type_d = evt_type_q;
		evt_cnt_d  = evt_cnt_q;
		ctr_we     = 1'b0;
		produce    = 1'b0;
		res_kind   = KIND_PIXEL;
		res_row    = '0;
		res_chan   = '0;
		res_ferr   = 1'b0;
		if (advance) begin
			unique case (phase_q)
				PH_SEARCH: begin
					if (item.word == cfg.header_word) begin
						herr_d     = skipped_q;
						skipped_d  = 1'b0;
						derr_d     = 1'b0;
						evt_type_d = '0;
						evt_cnt_d  = '0;
						row_d      = '0;
						widx_d     = '0;
						phase_d    = PH_ROWS;
					end else begin
						skipped_d = 1'b1;
					end
				end
				PH_FOOTER: begin
					produce   = 1'b1;
					res_kind  = KIND_SUMMARY;
					res_ferr  = (item.word != cfg.footer_word);
					phase_d   = PH_SEARCH;
					skipped_d = 1'b0;
				end
				PH_ROWS: begin
					if (widx_q == '0) begin
						// row header: id, event type, row number, counter steps
						if (item.word[31:28] != ROW_HDR_ID ||
								item.word[27:26] != ROW_EVT_TYPE ||
								item.word[25:20] != row_q ||
								item.word[19:16] != prev_ctr[19:16] + C4_W'(1) ||
								item.word[15:0] != prev_ctr[15:0] + C16_W'(1)) begin
							derr_d = 1'b1;
						end
						ctr_we = 1'b1;
						if (row_q == EVENT_ROW) begin
							evt_type_d = item.word[27:26];
							evt_cnt_d  = item.word[15:0];
						end
					end else if (widx_q <= WIDX_DATA) begin
						produce  = 1'b1;
						res_row  = row_q;
						res_chan = {widx_m1[CHAN_W-2:0], 1'b0};
					end else begin
						if (item.word[23:20] != ROW_FTR_ID) begin
							derr_d = 1'b1;
						end
					end
					// word and row counters
					if (widx_q == WIDX_LAST) begin
						widx_d = '0;
						if (row_q == ROW_LAST) begin
							row_d   = '0;
							phase_d = PH_FOOTER;
						end else begin
							row_d = row_q + ROW_W'(1);
						end
					end else begin
						widx_d = widx_q + WIDX_W'(1);
					end
				end
				default: begin
					phase_d = PH_SEARCH;
				end
			endcase
		end
	end

	// state, counter valid bits and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SEARCH;
			row_q         <= '0;
			widx_q        <= '0;
			skipped_q     <= 1'b0;
			herr_q        <= 1'b0;
			derr_q        <= 1'b0;
			evt_type_q    <= '0;
			evt_cnt_q     <= '0;
			ctr_vld_q     <= '0;
			out_valid     <= 1'b0;
			kind          <= 1'b0;
			row           <= '0;
			channel       <= '0;
			adc_even      <= '0;
			adc_odd       <= '0;
			header_error  <= 1'b0;
			data_error    <= 1'b0;
			footer_error  <= 1'b0;
			frame_error   <= 1'b0;
			evt_type      <= '0;
			evt_count     <= '0;
		end else begin
			phase_q    <= phase_d;
			row_q      <= row_d;
			widx_q     <= widx_d;
			skipped_q  <= skipped_d;
			herr_q     <= herr_d;
			derr_q     <= derr_d;
			evt_type_q <= evt_type_d;
			evt_cnt_q  <= evt_cnt_d;
			if (ctr_we) begin
				ctr_vld_q[row_q[AW-1:0]] <= 1'b1;
			end
			if (advance) begin
				out_valid <= produce;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (advance && produce) begin
				kind     <= res_kind;
				row      <= res_row;
				channel  <= res_chan;
				if (res_kind == KIND_PIXEL) begin
					adc_even      <= item.word[15:0];
					adc_odd       <= item.word[31:16];
					header_error  <= 1'b0;
					data_error    <= 1'b0;
					footer_error  <= 1'b0;
					frame_error   <= 1'b0;
					evt_type      <= '0;
					evt_count     <= '0;
				end else begin
					adc_even      <= '0;
					adc_odd       <= '0;
					header_error  <= herr_q;
					data_error    <= derr_q;
					footer_error  <= res_ferr;
					frame_error   <= herr_q || derr_q || res_ferr;
					evt_type      <= evt_type_q;
					evt_count     <= evt_cnt_q;
				end
			end
		end
	end

endmodule

// ----- rtl/pixel_frame_deframer_checker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_frame_deframer_checker_core: readout frame deframer and checker
// Finds the frame header, splits rows into pixel sample pairs, checks row
// headers/footers and the frame footer, and emits a summary per frame.
//
//   channel   signals                          transfer
//   input     in_valid, in_stall, word         in_valid && !in_stall
//   output    out_valid, out_stall, kind..     out_valid && !out_stall
//   config    cfg_write, cfg_index, cfg_data   cfg_write
//
// One word per cycle while no result is stalled; a word's result passes through
// the input register, then the result register.
// Row counters sit in a RAM read one word ahead; valid bits per row, cleared
// by reset, make unwritten rows read as zero, so no clearing pass is needed.
// A stalled result holds; the input register still takes one more word.
// Reset is asynchronous, active low, and returns to header search.
// ----------------------------------------------------------------------------
module pixel_frame_deframer_checker_core #(
	parameter int ROWS     = 48,
	parameter int CHANNELS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [0:0]                  cfg_index,
	input  logic [pfdc_pkg::WORD_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [pfdc_pkg::WORD_W-1:0] word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        kind,
	output logic [pfdc_pkg::ROW_W-1:0]  row,
	output logic [pfdc_pkg::CHAN_W-1:0] channel,
	output logic [pfdc_pkg::ADC_W-1:0]  adc_even,
	output logic [pfdc_pkg::ADC_W-1:0]  adc_odd,
	output logic                        header_error,
	output logic                        data_error,
	output logic                        footer_error,
	output logic                        frame_error,
	output logic [pfdc_pkg::EVT_W-1:0]  evt_type,
	output logic [pfdc_pkg::C16_W-1:0]  evt_count
);
	import pfdc_pkg::*;

	pfdc_cfg_t  cfg_q;
	pfdc_item_t item;
	logic       advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_word <= HEADER_WORD_RST;
			cfg_q.footer_word <= FOOTER_WORD_RST;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_HEADER_WORD: cfg_q.header_word <= cfg_data;
				REG_FOOTER_WORD: cfg_q.footer_word <= cfg_data;
				default: ;
			endcase
		end
	end

	pfdc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.word     (word),
		.advance  (advance),
		.item     (item)
	);

	pfdc_engine #(
		.ROWS     (ROWS),
		.CHANNELS (CHANNELS)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.item          (item),
		.advance       (advance),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.row           (row),
		.channel       (channel),
		.adc_even      (adc_even),
		.adc_odd       (adc_odd),
		.header_error  (header_error),
		.data_error    (data_error),
		.footer_error  (footer_error),
		.frame_error   (frame_error),
		.evt_type      (evt_type),
		.evt_count     (evt_count)
	);

	// input backs up only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled result");

	// summary flag is the OR of the three error flags
	a_frame_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind) |->
			(frame_error == (header_error || data_error || footer_error)))
		else $error("frame_error inconsistent");

	// pixel pairs carry an in-range row and no frame flags
	a_pixel_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !kind) |->
			(row <= ROW_W'(ROWS - 1) && !frame_error && !channel[0]))
		else $error("pixel result out of range");

	// a result not taken stays valid
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(kind) && $stable(adc_even)))
		else $error("stalled result changed");

endmodule
